[hdl/vtd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_pkg
// Shared widths, register indexes, filter coefficients and pipeline types for
// the vertical-temporal deinterlacer.
// ----------------------------------------------------------------------------
package vtd_pkg;

  localparam int unsigned SMP_W     = 8;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned FH_W      = 13;
  localparam int unsigned NUM_ODD   = 4;
  localparam int unsigned NUM_EVEN  = 5;
  localparam int unsigned NUM_TAP   = NUM_ODD + NUM_EVEN;
  localparam int unsigned KIDX_W    = 3;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned SUM_W     = 28;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NUM_PART  = 3;
  localparam int unsigned PART_LEN  = NUM_TAP / NUM_PART;

  localparam logic [SMP_W-1:0] PIX_MAX = 8'd255;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_KEPT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd2;

  localparam int unsigned FH_RESET = 1080;

  // tap row offsets: odd taps -3..+3, then even taps -4..+4
  localparam int TAP_OFF [NUM_TAP] = '{-3, -1, 1, 3, -4, -2, 0, 2, 4};
  // half range of each tap's supplied rows
  localparam int TAP_LO  [NUM_TAP] = '{3, 3, 3, 3, 4, 4, 4, 4, 4};

  // low-frequency coefficients on odd taps, per filter_select
  localparam logic signed [COEF_W-1:0] LF_COEF [2][NUM_ODD] = '{
    '{18'sd0, 18'sd32768, 18'sd32768, 18'sd0},
    '{-18'sd1704, 18'sd34472, 18'sd34472, -18'sd1704}
  };

  // high-frequency coefficients on even taps, per filter_select
  localparam logic signed [COEF_W-1:0] HF_COEF [2][NUM_EVEN] = '{
    '{18'sd0, -18'sd4096, 18'sd8192, -18'sd4096, 18'sd0},
    '{18'sd2032, -18'sd7602, 18'sd11140, -18'sd7602, 18'sd2032}
  };

  typedef logic [NUM_ODD-1:0][SMP_W-1:0]  odd_smp_t;
  typedef logic [NUM_EVEN-1:0][SMP_W-1:0] even_smp_t;
  typedef logic [NUM_EVEN-1:0][SMP_W:0]   hf_smp_t;

  typedef struct packed {
    logic             valid;
    logic             kept;
    logic             fsel;
    logic [SMP_W-1:0] center;
  } vtd_ctl_t;

endpackage

[hdl/vertical_temporal_deinterlacer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_temporal_deinterlacer_core
// Throughput: one word per cycle when the output is not stalled; five register
// stages (reflect, select, multiply, partial sum, final sum and clamp) all
// advance together.
// Output stall freezes every stage; no word is dropped or repeated.
// Reset clears all valid bits and loads top_kept=1, filter_select=0,
// frame_height=1080 (limited to MAX_ROWS).
// ----------------------------------------------------------------------------
module vertical_temporal_deinterlacer_core import vtd_pkg::*; #(
  parameter int unsigned MAX_ROWS = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FH_W-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ROW_W-1:0]     row_i,
  input  logic [31:0]          cur_odd_taps_i,
  input  logic [39:0]          cur_even_taps_i,
  input  logic [39:0]          adj_even_taps_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SMP_W-1:0]     out_pixel_o
);

  localparam int unsigned HW      = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW      = ((HW > FH_W) ? HW : FH_W) + 1;
  localparam int unsigned H_RESET = (MAX_ROWS < FH_RESET) ? MAX_ROWS : FH_RESET;

  logic          top_kept_q;
  logic          fsel_q;
  logic [HW-1:0] height_d;
  logic [HW-1:0] height_q;
  logic [CW-1:0] fh_ext;
  logic          en;

  vtd_ctl_t  ctl;
  odd_smp_t  odd_smp;
  hf_smp_t   hf_smp;

  // limit the height to 2..MAX_ROWS once, at write time
  always_comb begin
    fh_ext = CW'(cfg_data_i);
    if (fh_ext < CW'(2)) begin
      height_d = HW'(2);
    end else if (fh_ext > CW'(MAX_ROWS)) begin
      height_d = HW'(MAX_ROWS);
    end else begin
      height_d = fh_ext[HW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_kept_q <= 1'b1;
      fsel_q     <= 1'b0;
      height_q   <= HW'(H_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TOP_KEPT:      top_kept_q <= cfg_data_i[0];
        REG_FILTER_SELECT: fsel_q     <= cfg_data_i[0];
        REG_FRAME_HEIGHT:  height_q   <= height_d;
        default: ;
      endcase
    end
  end

  // hold the whole pipe while the output word waits
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  vtd_tap_sel #(
    .HW(HW)
  ) u_tap_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .row_i      (row_i),
    .odd_i      (cur_odd_taps_i),
    .cur_i      (cur_even_taps_i),
    .adj_i      (adj_even_taps_i),
    .top_kept_i (top_kept_q),
    .fsel_i     (fsel_q),
    .height_i   (height_q),
    .ctl_o      (ctl),
    .odd_smp_o  (odd_smp),
    .hf_smp_o   (hf_smp)
  );

  vtd_filter u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctl_i     (ctl),
    .odd_smp_i (odd_smp),
    .hf_smp_i  (hf_smp),
    .valid_o   (out_valid_o),
    .pixel_o   (out_pixel_o)
  );

endmodule

[hdl/vtd_tap_sel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_tap_sel
// Two pipeline stages: reflect each tap row at the plane edges into a byte
// index, then pick the samples and pre-add current and adjacent even rows.
// ----------------------------------------------------------------------------
module vtd_tap_sel import vtd_pkg::*; #(
  parameter int unsigned HW = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [ROW_W-1:0]      row_i,
  input  odd_smp_t              odd_i,
  input  even_smp_t             cur_i,
  input  even_smp_t             adj_i,
  input  logic                  top_kept_i,
  input  logic                  fsel_i,
  input  logic [HW-1:0]         height_i,
  output vtd_ctl_t              ctl_o,
  output odd_smp_t              odd_smp_o,
  output hf_smp_t               hf_smp_o
);

  localparam int unsigned YW = ((HW > ROW_W) ? HW : ROW_W) + 2;

  logic signed [YW-1:0] row_ext;
  logic signed [YW-1:0] h_ext;
  logic signed [YW-1:0] hm1_ext;
  logic signed [YW-1:0] hm2_ext;

  logic [NUM_TAP-1:0][KIDX_W-1:0] kidx_d;

  // stage A
  logic                           valid_a_q;
  logic                           kept_a_q;
  logic                           fsel_a_q;
  odd_smp_t                       odd_a_q;
  even_smp_t                      cur_a_q;
  even_smp_t                      adj_a_q;
  logic [NUM_TAP-1:0][KIDX_W-1:0] kidx_a_q;

  // stage B
  vtd_ctl_t  ctl_d;
  vtd_ctl_t  ctl_q;
  odd_smp_t  odd_smp_d;
  odd_smp_t  odd_smp_q;
  hf_smp_t   hf_smp_d;
  hf_smp_t   hf_smp_q;

  assign row_ext = $signed(YW'(row_i));
  assign h_ext   = $signed(YW'(height_i));
  assign hm1_ext = YW'(h_ext - 1);
  assign hm2_ext = YW'(h_ext - 2);

  // reflect in steps of two, then saturate to the supplied rows
  always_comb begin : p_reflect
    logic signed [YW-1:0] y0;
    logic signed [YW-1:0] y1;
    logic signed [YW-1:0] dd;
    logic signed [YW-1:0] dk;
    y0 = '0;
    y1 = '0;
    dd = '0;
    dk = '0;
    for (int t = 0; t < NUM_TAP; t++) begin
      y0 = YW'(row_ext + TAP_OFF[t]);
      y1 = y0;
      if (y0 < 0) begin
        y1 = YW'(y0[0]);
      end else if (y0 >= h_ext) begin
        y1 = (y0[0] ^ h_ext[0]) ? hm1_ext : hm2_ext;
      end
      dd = y1 - row_ext;
      if (dd < -TAP_LO[t]) begin
        dk = '0;
      end else if (dd > TAP_LO[t]) begin
        dk = YW'(2 * TAP_LO[t]);
      end else begin
        dk = YW'(dd + TAP_LO[t]);
      end
      kidx_d[t] = dk[KIDX_W:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kept_a_q <= (row_i[0] == ~top_kept_i);
      fsel_a_q <= fsel_i;
      odd_a_q  <= odd_i;
      cur_a_q  <= cur_i;
      adj_a_q  <= adj_i;
      kidx_a_q <= kidx_d;
    end
  end

  always_comb begin
    ctl_d.valid  = valid_a_q;
    ctl_d.kept   = kept_a_q;
    ctl_d.fsel   = fsel_a_q;
    ctl_d.center = cur_a_q[2];
    for (int i = 0; i < NUM_ODD; i++) begin
      odd_smp_d[i] = odd_a_q[kidx_a_q[i][1:0]];
    end
    for (int i = 0; i < NUM_EVEN; i++) begin
      hf_smp_d[i] = {1'b0, cur_a_q[kidx_a_q[NUM_ODD+i]]}
                  + {1'b0, adj_a_q[kidx_a_q[NUM_ODD+i]]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      odd_smp_q <= odd_smp_d;
      hf_smp_q  <= hf_smp_d;
    end
  end

  assign ctl_o     = ctl_q;
  assign odd_smp_o = odd_smp_q;
  assign hf_smp_o  = hf_smp_q;

endmodule

[hdl/vtd_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_filter
// Three pipeline stages: coefficient products, partial sums, then the final
// sum with clamp to 0..255 (or the centre sample for kept rows).
// ----------------------------------------------------------------------------
module vtd_filter import vtd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  vtd_ctl_t         ctl_i,
  input  odd_smp_t         odd_smp_i,
  input  hf_smp_t          hf_smp_i,
  output logic             valid_o,
  output logic [SMP_W-1:0] pixel_o
);

  logic signed [SUM_W-1:0] prod_d [NUM_TAP];
  logic signed [SUM_W-1:0] prod_q [NUM_TAP];
  vtd_ctl_t                ctl_c_q;

  logic signed [SUM_W-1:0] part_d [NUM_PART];
  logic signed [SUM_W-1:0] part_q [NUM_PART];
  vtd_ctl_t                ctl_p_q;

  logic signed [SUM_W-1:0] sum;
  logic [SMP_W-1:0]        pixel_d;
  logic [SMP_W-1:0]        pixel_q;
  logic                    valid_q;

  always_comb begin : p_mult
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] c;
    a = '0;
    c = '0;
    for (int i = 0; i < NUM_ODD; i++) begin
      a = SUM_W'($signed({1'b0, odd_smp_i[i]}));
      c = SUM_W'(LF_COEF[ctl_i.fsel][i]);
      prod_d[i] = a * c;
    end
    for (int i = 0; i < NUM_EVEN; i++) begin
      a = SUM_W'($signed({1'b0, hf_smp_i[i]}));
      c = SUM_W'(HF_COEF[ctl_i.fsel][i]);
      prod_d[NUM_ODD+i] = a * c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= '0;
      ctl_p_q <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      ctl_c_q <= ctl_i;
      ctl_p_q <= ctl_c_q;
      valid_q <= ctl_p_q.valid;
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PART; p++) begin
      part_d[p] = prod_q[PART_LEN*p] + prod_q[PART_LEN*p+1] + prod_q[PART_LEN*p+2];
    end
  end

  always_comb begin
    sum = part_q[0] + part_q[1] + part_q[2];
    if (ctl_p_q.kept) begin
      pixel_d = ctl_p_q.center;
    end else if (sum[SUM_W-1]) begin
      pixel_d = '0;
    end else if (|sum[SUM_W-2:FRAC_BITS+SMP_W]) begin
      pixel_d = PIX_MAX;
    end else begin
      pixel_d = sum[FRAC_BITS +: SMP_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      part_q  <= part_d;
      pixel_q <= pixel_d;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

[hdl/vtd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtd_checker
// Port-level checks on the deinterlacer handshakes and pipeline latency.
// ----------------------------------------------------------------------------
module vtd_checker import vtd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [SMP_W-1:0] out_pixel_o
);

  // a stalled output word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_pixel_o))
    else $error("output word changed while stalled");

  // input side only stalls behind a held output word
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // an accepted word reaches the output if no stall comes between
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !in_stall_o ##1 !in_stall_o
      ##1 !in_stall_o ##1 !in_stall_o |=> out_valid_o)
    else $error("accepted word did not reach the output");

endmodule

bind vertical_temporal_deinterlacer_core vtd_checker u_vtd_checker (.*);

[sim/tb_vertical_temporal_deinterlacer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertical_temporal_deinterlacer_core
// Self-checking bench for the vertical-temporal deinterlacer core. A short
// table of directed words covers kept-row pass-through, both filters, clamping
// at 0 and 255, edge reflection and out-of-range heights and rows. Random
// phases follow, each under a new register setting. Each accepted word gets
// its pinned pixel or one from a local pixel predictor; the expected pixels
// are checked in order at the output; both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_vertical_temporal_deinterlacer_core;
  import vtd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // write is ignored
  localparam int PHASES        = 13;
  localparam int WORDS_PER_PHASE = 150;
  localparam int QUIET_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_AT_WORD  = 700;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    bit               top;
    bit               wide;
    int               rows;
    logic [ROW_W-1:0] row;
    logic [31:0]      odd;
    logic [39:0]      cur;
    logic [39:0]      adj;
    bit               pinned;
    logic [SMP_W-1:0] pix;
  } directed_word_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [FH_W-1:0]      cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [ROW_W-1:0]     row_i           = '0;
  logic [31:0]          cur_odd_taps_i  = '0;
  logic [39:0]          cur_even_taps_i = '0;
  logic [39:0]          adj_even_taps_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [SMP_W-1:0]     out_pixel_o;

  // typed expectation travelling with the current word
  logic             pin_valid = 1'b0;
  logic [SMP_W-1:0] pin_pixel = '0;

  // register copy seen by the predictor
  bit keep_top    = 1'b1;
  bit long_filter = 1'b0;
  int plane_rows  = FH_RESET;

  logic [SMP_W-1:0] expected_pixels[$];
  directed_word_t   directed_words[$];
  int words_in     = 0;
  int fail_count   = 0;
  int quiet_cycles = 0;

  // sender pacing
  bit offering  = 1'b0;
  bit gaps_on   = 1'b1;
  int burst_left = 0;
  bit prog_top  = 1'b1;
  bit prog_wide = 1'b0;
  int prog_rows = FH_RESET;

  vertical_temporal_deinterlacer_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .row_i           (row_i),
    .cur_odd_taps_i  (cur_odd_taps_i),
    .cur_even_taps_i (cur_even_taps_i),
    .adj_even_taps_i (adj_even_taps_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_pixel_o     (out_pixel_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // pixel predictor
  // --------------------------------------------------------------------------
  function automatic int lf_weight(bit wide, int j);
    if (!wide) return 32768;
    return (j == 0 || j == 3) ? -1704 : 34472;
  endfunction

  function automatic int hf_weight(bit wide, int j);
    if (!wide) return (j == 1) ? 8192 : -4096;
    if (j == 0 || j == 4) return 2032;
    return (j == 2) ? 11140 : -7602;
  endfunction

  // mirror the tap row back into the plane, then limit to the supplied rows
  function automatic int mirrored_offset(int r, int off, int h, int span);
    int y;
    int d;
    y = r + off;
    if (y < 0) y = y & 1;
    if (y >= h) y = (((y - h + 1) & 1) == 0) ? h - 1 : h - 2;
    d = y - r;
    if (d < -span) d = -span;
    if (d > span) d = span;
    return d;
  endfunction

  function automatic logic [SMP_W-1:0] interp_pixel(logic [ROW_W-1:0] row,
      logic [31:0] odd, logic [39:0] cur, logic [39:0] adj);
    int h;
    int r;
    int sum;
    int d;
    int k;
    int nlf;
    int nhf;
    int res;
    h = plane_rows;
    if (h < 2) h = 2;
    if (h > 4096) h = 4096;
    r = int'(row);
    if (row[0] == !keep_top) return cur[23:16];
    nlf = long_filter ? 4 : 2;
    nhf = long_filter ? 5 : 3;
    sum = 0;
    for (int j = 0; j < nlf; j++) begin
      d = mirrored_offset(r, 1 + 2 * j - nlf, h, 3);
      k = (d + 3) / 2;
      sum += int'(odd[8*k +: 8]) * lf_weight(long_filter, j);
    end
    for (int j = 0; j < nhf; j++) begin
      d = mirrored_offset(r, 1 + 2 * j - nhf, h, 4);
      k = (d + 4) / 2;
      sum += int'(cur[8*k +: 8]) * hf_weight(long_filter, j);
      sum += int'(adj[8*k +: 8]) * hf_weight(long_filter, j);
    end
    if (sum < 0) return '0;
    res = sum >>> 16;
    if (res > 255) res = 255;
    return res[SMP_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // register shadow, prediction and output check
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [SMP_W-1:0] want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOP_KEPT:      keep_top    = cfg_data_i[0];
          REG_FILTER_SELECT: long_filter = cfg_data_i[0];
          REG_FRAME_HEIGHT:  plane_rows  = int'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        want = pin_valid ? pin_pixel
                         : interp_pixel(row_i, cur_odd_taps_i, cur_even_taps_i,
                                        adj_even_taps_i);
        expected_pixels.push_back(want);
        words_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("out_pixel: no word expected, got %0d", out_pixel_o);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_o !== want) begin
            $error("out_pixel: expected %0d, got %0d", want, out_pixel_o);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern in random stretches, one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int mode_left;
    int stall_pct;
    bit held;
    mode_left = 0;
    stall_pct = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && words_in >= HOLD_AT_WORD) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      out_stall_i <= ($urandom_range(1, 100) <= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  task automatic drop_valid();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic pace();
    int gap;
    if (!gaps_on) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      drop_valid();
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
  endtask

  // hold the word until it is taken
  task automatic send_word(logic [ROW_W-1:0] row, logic [31:0] odd,
                           logic [39:0] cur, logic [39:0] adj,
                           bit pinned, logic [SMP_W-1:0] pix);
    pace();
    in_valid_i      <= 1'b1;
    row_i           <= row;
    cur_odd_taps_i  <= odd;
    cur_even_taps_i <= cur;
    adj_even_taps_i <= adj;
    pin_valid       <= pinned;
    pin_pixel       <= pix;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    drop_valid();
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FH_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // load a setting; 1-bit registers get random upper bits
  task automatic load_setting(bit top, bit wide, int rows, bit all_regs);
    logic [FH_W-1:0] junk;
    settle();
    junk = FH_W'($urandom());
    if (all_regs || top != prog_top)
      write_reg(REG_TOP_KEPT, {junk[FH_W-1:1], top});
    junk = FH_W'($urandom());
    if (all_regs || wide != prog_wide)
      write_reg(REG_FILTER_SELECT, {junk[FH_W-1:1], wide});
    if (all_regs || rows != prog_rows)
      write_reg(REG_FRAME_HEIGHT, rows[FH_W-1:0]);
    if (all_regs && $urandom_range(0, 2) == 0)
      write_reg(REG_UNUSED, FH_W'($urandom()));
    cfg_we_i <= 1'b0;
    prog_top  = top;
    prog_wide = wide;
    prog_rows = rows;
  endtask

  task automatic add_row(bit top, bit wide, int rows, logic [ROW_W-1:0] row,
                         logic [31:0] odd, logic [39:0] cur, logic [39:0] adj,
                         bit pinned, logic [SMP_W-1:0] pix);
    directed_word_t w;
    w.top = top;   w.wide = wide;  w.rows = rows;  w.row = row;
    w.odd = odd;   w.cur = cur;    w.adj = adj;
    w.pinned = pinned;  w.pix = pix;
    directed_words.push_back(w);
  endtask

  // one column of 14 samples: noise, smooth area or hard black/white
  task automatic make_column(output logic [31:0] odd, output logic [39:0] cur,
                             output logic [39:0] adj);
    logic [111:0] col;
    int style;
    int base;
    int v;
    style = $urandom_range(0, 99);
    base  = $urandom_range(0, 255);
    for (int i = 0; i < 14; i++) begin
      if (style < 60) begin
        v = $urandom_range(0, 255);
      end else if (style < 85) begin
        v = base + $urandom_range(0, 40) - 20;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end else begin
        v = $urandom_range(0, 1) ? 255 : 0;
      end
      col[8*i +: 8] = v[7:0];
    end
    odd = col[31:0];
    cur = col[71:32];
    adj = col[111:72];
  endtask

  function automatic int pick_rows();
    case ($urandom_range(0, 11))
      0:  return $urandom_range(0, 1);
      1:  return 2;
      2:  return $urandom_range(3, 9);
      3:  return $urandom_range(10, 64);
      4:  return FH_RESET;
      5:  return $urandom_range(4095, 4097);
      6:  return 8191;
      7:  return $urandom_range(0, 8191);
      default: return $urandom_range(2, 4096);
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] pick_row(int rows);
    int h;
    int r;
    h = rows < 2 ? 2 : (rows > 4096 ? 4096 : rows);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r = $urandom_range(0, 9);
      4, 5, 6:    r = h - 1 - $urandom_range(0, 9);
      7, 8:       r = $urandom_range(0, h - 1);
      default:    r = $urandom_range(0, 4095);
    endcase
    if (r < 0) r = 0;
    return r[ROW_W-1:0];
  endfunction

  initial begin
    logic [31:0] odd;
    logic [39:0] cur;
    logic [39:0] adj;
    directed_word_t w;

    // reset setting: even rows kept, short filter, 1080 rows
    add_row(1, 0, 1080, 0,    32'h0, 40'h11_22_33_44_55, 40'h0, 1, 8'h33);
    add_row(1, 0, 1080, 1078, 32'h0, 40'hFF_FF_00_FF_FF, 40'h0, 1, 8'h00);
    add_row(1, 0, 1080, 1,    32'h0, 40'h0, 40'h0, 1, 8'h00);
    add_row(1, 0, 1080, 101,  '1, '1, '1, 1, 8'hFF);
    add_row(1, 0, 1080, 101,  '1, 40'h00_00_FF_00_00, 40'h0, 1, 8'hFF);
    add_row(1, 0, 1080, 101,  32'h0, 40'h00_FF_00_FF_00, 40'h00_FF_00_FF_00, 1, 8'h00);
    add_row(1, 0, 1080, 1,    32'h10_80_40_20, 40'h01_23_45_67_89, 40'h98_76_54_32_10,
            0, 8'h00);
    add_row(1, 0, 1080, 1079, 32'hF0_08_C4_2A, 40'h3C_A5_11_E0_7F, 40'h81_42_24_18_FF,
            0, 8'h00);
    add_row(1, 0, 1080, 4095, 32'h12_34_56_78, 40'hC0_FF_EE_00_11, 40'h22_33_44_55_66,
            0, 8'h00);
    add_row(1, 0, 1080, 4094, 32'h0, 40'hA5_5A_C3_3C_96, 40'h0, 1, 8'hC3);
    // odd rows kept, long filter
    add_row(0, 1, 1080, 0,    32'h40_80_C0_FF, 40'h10_20_30_40_50, 40'h60_70_80_90_A0,
            0, 8'h00);
    add_row(0, 1, 1080, 1,    32'h0, 40'h00_00_7E_00_00, 40'h0, 1, 8'h7E);
    add_row(0, 1, 1080, 540,  '1, '1, '1, 1, 8'hFF);
    add_row(0, 1, 1080, 540,  32'h80_7F_81_7E, 40'h70_90_60_A0_50, 40'h88_77_99_66_AA,
            0, 8'h00);
    add_row(0, 1, 1080, 1078, 32'h01_FE_02_FD, 40'hFF_00_FF_00_FF, 40'h00_FF_00_FF_00,
            0, 8'h00);
    add_row(0, 1, 1080, 2,    32'h0, 40'h0, 40'h0, 1, 8'h00);
    // smallest plane and heights outside the legal range
    add_row(1, 1, 2,    1,    32'h11_22_33_44, 40'h55_66_77_88_99, 40'hAA_BB_CC_DD_EE,
            0, 8'h00);
    add_row(1, 1, 2,    0,    32'h0, 40'h01_02_03_04_05, 40'h0, 1, 8'h03);
    add_row(0, 0, 0,    0,    32'hDE_AD_BE_EF, 40'h0F_1E_2D_3C_4B, 40'h5A_69_78_87_96,
            0, 8'h00);
    add_row(0, 0, 0,    3,    32'h9C_63_C9_36, 40'hE1_1E_D2_2D_C3, 40'hB4_4B_A5_5A_96,
            0, 8'h00);
    add_row(1, 0, 1,    1,    32'h77_88_99_AA, 40'hBB_CC_DD_EE_FF, 40'h00_11_22_33_44,
            0, 8'h00);
    add_row(1, 1, 8191, 4095, 32'h31_41_59_26, 40'h53_58_97_93_23, 40'h84_62_64_33_83,
            0, 8'h00);
    add_row(1, 1, 8191, 4093, 32'hFF_00_FF_00, 40'h00_FF_00_FF_00, 40'hFF_00_FF_00_FF,
            0, 8'h00);
    add_row(0, 1, 4096, 4094, 32'h27_18_28_18, 40'h28_45_90_45_23, 40'h53_60_28_74_71,
            0, 8'h00);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_words[i]) begin
      w = directed_words[i];
      if (w.top != prog_top || w.wide != prog_wide || w.rows != prog_rows)
        load_setting(w.top, w.wide, w.rows, 1'b0);
      send_word(w.row, w.odd, w.cur, w.adj, w.pinned, w.pix);
    end

    for (int p = 0; p < PHASES; p++) begin
      load_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_rows(),
                   1'b1);
      gaps_on = (p % 4 != 3);
      burst_left = 0;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        make_column(odd, cur, adj);
        send_word(pick_row(prog_rows), odd, cur, adj, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
